### src/rsd_pkg.sv
// ----------------------------------------------------------------------------
// rsd_pkg
// Shared types and constants for the relocation stream decoder.
// ----------------------------------------------------------------------------
package rsd_pkg;

  localparam int unsigned OffsetW = 32;
  localparam int unsigned DigitW  = 7;
  localparam int unsigned QDepth  = 4;
  localparam int unsigned QPtrW   = $clog2(QDepth);
  localparam int unsigned QCntW   = $clog2(QDepth + 1);

  localparam logic [7:0] ByteSelector = 8'h00;  // selector marker / zero step
  localparam logic [7:0] ByteScale    = 8'h08;  // advance *= 128

  typedef enum logic [1:0] {
    KIND_OFFSET32   = 2'd0,
    KIND_SELECTOR16 = 2'd1,
    KIND_END        = 2'd2
  } kind_e;

  // One queue entry: the results a single code byte produces.
  // A second result only ever comes from the end of the table.
  typedef struct packed {
    logic [OffsetW-1:0] off_a;
    kind_e              kind_a;
    logic               last_a;
    logic               has_b;
    logic [OffsetW-1:0] off_b;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

### src/rsd_front.sv
// ----------------------------------------------------------------------------
// rsd_front
// Takes code bytes, keeps the decode state and builds the result entries.
// ----------------------------------------------------------------------------
module rsd_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [7:0]                    code_byte_i,
  input  logic                          table_end_i,
  input  rsd_pkg::q_status_t            q_status_i,
  output logic                          push_o,
  output rsd_pkg::entry_t               push_entry_o
);

  logic [rsd_pkg::OffsetW-1:0] ro_q, ro_d;
  logic [rsd_pkg::OffsetW-1:0] adv_q, adv_d;
  logic                        pend_q, pend_d;

  logic                        accept;
  logic [rsd_pkg::DigitW-1:0]  digit;
  logic                        r0_valid;
  rsd_pkg::kind_e              r0_kind;
  logic                        pend_mid;
  logic [rsd_pkg::OffsetW-1:0] ro_mid;
  logic [rsd_pkg::OffsetW-1:0] adv_mid;

  assign in_stall_o = q_status_i.full;
  assign accept     = in_valid_i && !q_status_i.full;
  // nibble swap, top bit of the digit dropped
  assign digit      = {code_byte_i[2:0], code_byte_i[7:4]};

  // byte decode
  always_comb begin
    r0_valid = 1'b0;
    r0_kind  = rsd_pkg::KIND_OFFSET32;
    pend_mid = pend_q;
    ro_mid   = ro_q;
    adv_mid  = adv_q;
    if (code_byte_i == rsd_pkg::ByteSelector) begin
      if (pend_q) begin
        r0_valid = 1'b1;
        r0_kind  = rsd_pkg::KIND_SELECTOR16;
        pend_mid = 1'b0;
      end else begin
        ro_mid   = ro_q + adv_q;
        adv_mid  = '0;
        pend_mid = 1'b1;
      end
    end else if (code_byte_i == rsd_pkg::ByteScale) begin
      adv_mid = {adv_q[rsd_pkg::OffsetW-8:0], 7'd0};
    end else begin
      r0_valid = pend_q;
      if (!code_byte_i[3]) begin
        ro_mid   = ro_q + adv_q + {{(rsd_pkg::OffsetW-rsd_pkg::DigitW){1'b0}}, digit};
        adv_mid  = '0;
        pend_mid = 1'b1;
      end else begin
        ro_mid   = ro_q + adv_q;
        adv_mid  = {{(rsd_pkg::OffsetW-rsd_pkg::DigitW-7){1'b0}}, digit, 7'd0};
        pend_mid = 1'b0;
      end
    end
  end

  // entry assembly, end-of-table flush
  always_comb begin
    push_entry_o        = '0;
    push_entry_o.kind_a = r0_kind;
    push_o              = 1'b0;
    if (r0_valid) begin
      push_o              = 1'b1;
      push_entry_o.off_a  = ro_q;
      push_entry_o.last_a = table_end_i && !pend_mid;
      push_entry_o.has_b  = table_end_i && pend_mid;
      push_entry_o.off_b  = ro_mid;
    end else if (table_end_i) begin
      push_o              = 1'b1;
      push_entry_o.last_a = 1'b1;
      if (pend_mid) begin
        push_entry_o.off_a  = ro_mid;
        push_entry_o.kind_a = rsd_pkg::KIND_OFFSET32;
      end else begin
        push_entry_o.kind_a = rsd_pkg::KIND_END;
      end
    end
    push_o = push_o && accept;
  end

  always_comb begin
    ro_d   = ro_q;
    adv_d  = adv_q;
    pend_d = pend_q;
    if (accept) begin
      if (table_end_i) begin
        ro_d   = '0;
        adv_d  = '0;
        pend_d = 1'b0;
      end else begin
        ro_d   = ro_mid;
        adv_d  = adv_mid;
        pend_d = pend_mid;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ro_q   <= '0;
      adv_q  <= '0;
      pend_q <= 1'b0;
    end else begin
      ro_q   <= ro_d;
      adv_q  <= adv_d;
      pend_q <= pend_d;
    end
  end

endmodule

### src/rsd_queue.sv
// ----------------------------------------------------------------------------
// rsd_queue
// Small register FIFO of result entries between front and back.
// ----------------------------------------------------------------------------
module rsd_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  rsd_pkg::entry_t    push_entry_i,
  input  logic               pop_i,
  output rsd_pkg::entry_t    head_o,
  output rsd_pkg::q_status_t status_o
);

  rsd_pkg::entry_t                 mem_q [rsd_pkg::QDepth];
  logic [rsd_pkg::QPtrW-1:0]       wr_q, wr_d;
  logic [rsd_pkg::QPtrW-1:0]       rd_q, rd_d;
  logic [rsd_pkg::QCntW-1:0]       cnt_q, cnt_d;
  logic                            do_pop;

  assign status_o.full  = (cnt_q == rsd_pkg::QCntW'(rsd_pkg::QDepth));
  assign status_o.empty = (cnt_q == '0);
  assign head_o         = mem_q[rd_q];
  assign do_pop         = pop_i && !status_o.empty;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = rd_q + 1'b1;
    end
    if (push_i && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_entry_i;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= rsd_pkg::QCntW'(rsd_pkg::QDepth))
    else $error("queue count beyond depth");

endmodule

### src/rsd_back.sv
// ----------------------------------------------------------------------------
// rsd_back
// Unpacks queue entries into single result beats behind an output register.
// ----------------------------------------------------------------------------
module rsd_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  rsd_pkg::entry_t             head_i,
  input  rsd_pkg::q_status_t          q_status_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [rsd_pkg::OffsetW-1:0] reloc_offset_o,
  output logic [1:0]                  reloc_kind_o,
  output logic                        last_of_table_o
);

  logic                        out_valid_q, out_valid_d;
  logic                        sub_q, sub_d;    // first result of head already sent
  logic [rsd_pkg::OffsetW-1:0] off_q, off_d;
  rsd_pkg::kind_e              kind_q, kind_d;
  logic                        last_q, last_d;
  logic                        load;

  assign load = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    sub_d       = sub_q;
    off_d       = off_q;
    kind_d      = kind_q;
    last_d      = last_q;
    pop_o       = 1'b0;
    if (load) begin
      out_valid_d = !q_status_i.empty;
      if (!q_status_i.empty) begin
        if (sub_q) begin
          off_d  = head_i.off_b;
          kind_d = rsd_pkg::KIND_OFFSET32;
          last_d = 1'b1;
          sub_d  = 1'b0;
          pop_o  = 1'b1;
        end else begin
          off_d  = head_i.off_a;
          kind_d = head_i.kind_a;
          last_d = head_i.last_a;
          sub_d  = head_i.has_b;
          pop_o  = !head_i.has_b;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      sub_q       <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      sub_q       <= sub_d;
    end
  end

  always_ff @(posedge clk_i) begin
    off_q  <= off_d;
    kind_q <= kind_d;
    last_q <= last_d;
  end

  assign out_valid_o     = out_valid_q;
  assign reloc_offset_o  = off_q;
  assign reloc_kind_o    = kind_q;
  assign last_of_table_o = last_q;

  a_sub_shown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sub_q |-> out_valid_q)
    else $error("second result pending without first on output");

  a_sub_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sub_q |-> !q_status_i.empty)
    else $error("second result pending but queue empty");

  a_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && kind_q == rsd_pkg::KIND_END) |-> (last_q && off_q == '0))
    else $error("end marker not last or nonzero offset");

endmodule

### src/relocation_stream_decoder.sv
// ----------------------------------------------------------------------------
// relocation_stream_decoder
// Decodes a compact relocation code stream into offset/selector relocations.
// ----------------------------------------------------------------------------
// A byte's results are written into the queue and reach the output through the back's output register.
// Throughput: one byte per cycle while the queue is not full; each result takes
//   one output beat, so a byte with two results holds the output for two beats,
//   absorbed by the four-entry queue. Input stalls only when that queue is full.
// Reset: rst_ni clears the decode state, the queue and the output valid.
module relocation_stream_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  // code byte channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  code_byte_i,
  input  logic        table_end_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] reloc_offset_o,
  output logic [1:0]  reloc_kind_o,
  output logic        last_of_table_o
);

  // Front: per-byte decode. Keeps running offset, banked advance and the
  // pending-entry flag; packs the zero, one or two results of a beat into
  // one queue entry. End of table flushes and returns state to reset values.
  logic               push;
  rsd_pkg::entry_t    push_entry;
  // Queue status goes back to the front (stall) and on to the back (empty).
  rsd_pkg::q_status_t q_status;
  rsd_pkg::entry_t    head;
  logic               pop;

  rsd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .code_byte_i  (code_byte_i),
    .table_end_i  (table_end_i),
    .q_status_i   (q_status),
    .push_o       (push),
    .push_entry_o (push_entry)
  );

  // Decouples decode from the output side so each may stall on its own.
  rsd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .pop_i        (pop),
    .head_o       (head),
    .status_o     (q_status)
  );

  // Back: splits an entry into result beats, in stream order, behind a
  // registered output so the front keeps taking bytes while a beat waits.
  rsd_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_i          (head),
    .q_status_i      (q_status),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .reloc_offset_o  (reloc_offset_o),
    .reloc_kind_o    (reloc_kind_o),
    .last_of_table_o (last_of_table_o)
  );

endmodule

### sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Testbench for relocation_stream_decoder. Code bytes are pushed through the
// valid/stall input channel and every output beat is checked against a
// bit-exact decoder model kept in a small tracker class. Short directed
// tables come first, then random tables and stray bytes. Both channels idle
// at random, and once the result side holds off long enough to back the
// decoder up into its input.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned CodeItems   = 1300;
  localparam int unsigned TailItems   = 150;   // no idling on either side
  localparam int unsigned HoldCycles  = 200;   // long result-side hold-off
  localparam int unsigned HoldAtItem  = 500;
  localparam int unsigned DrainCycles = 20;
  localparam int unsigned CycleLimit  = 400000;

  typedef struct {
    logic [rsd_pkg::OffsetW-1:0] off;
    rsd_pkg::kind_e              kind;
    logic                        last_flag;
  } reloc_t;

  // Decoder model plus the in-order list of relocations still owed.
  class reloc_tracker;
    logic [rsd_pkg::OffsetW-1:0] run_off;
    logic [rsd_pkg::OffsetW-1:0] bank_adv;
    bit                          entry_open;
    reloc_t                      due_relocs[$];
    int                          errors;

    function new();
      errors = 0;
      clear_table();
    endfunction

    function void clear_table();
      run_off    = '0;
      bank_adv   = '0;
      entry_open = 1'b0;
    endfunction

    function void owe(logic [rsd_pkg::OffsetW-1:0] off, rsd_pkg::kind_e kind);
      reloc_t r;
      r.off       = off;
      r.kind      = kind;
      r.last_flag = 1'b0;
      due_relocs.insert(due_relocs.size(), r);
    endfunction

    // Note one accepted code beat and queue what it produces.
    function void take_byte(logic [7:0] b, logic tbl_end);
      logic [rsd_pkg::DigitW-1:0] digit;
      int                         n_before;
      digit    = {b[2:0], b[7:4]};
      n_before = due_relocs.size();
      if (b == rsd_pkg::ByteSelector) begin
        if (entry_open) begin
          owe(run_off, rsd_pkg::KIND_SELECTOR16);
          entry_open = 1'b0;
        end else begin
          // zero displacement: flush the advance and open an entry
          run_off    = run_off + bank_adv;
          bank_adv   = '0;
          entry_open = 1'b1;
        end
      end else if (b == rsd_pkg::ByteScale) begin
        bank_adv = bank_adv << 7;
      end else begin
        if (entry_open) begin
          owe(run_off, rsd_pkg::KIND_OFFSET32);
          entry_open = 1'b0;
        end
        if (!b[3]) begin
          run_off    = run_off + bank_adv + rsd_pkg::OffsetW'(digit);
          bank_adv   = '0;
          entry_open = 1'b1;
        end else begin
          run_off  = run_off + bank_adv;
          bank_adv = rsd_pkg::OffsetW'(digit) << 7;
        end
      end
      if (tbl_end) begin
        if (entry_open) owe(run_off, rsd_pkg::KIND_OFFSET32);
        if (due_relocs.size() == n_before) owe('0, rsd_pkg::KIND_END);
        due_relocs[due_relocs.size()-1].last_flag = 1'b1;
        clear_table();
      end
    endfunction

    // Compare one accepted result beat with the oldest owed relocation.
    function void match_reloc(logic [31:0] off, logic [1:0] kind, logic last_flag);
      reloc_t want;
      if (due_relocs.size() == 0) begin
        $error("unexpected result beat: offset %h kind %0d last %0b", off, kind, last_flag);
        errors++;
        return;
      end
      want = due_relocs.pop_front();
      if (off !== want.off) begin
        $error("reloc_offset: expected %h, got %h", want.off, off);
        errors++;
      end
      if (kind !== 2'(want.kind)) begin
        $error("reloc_kind: expected %0d, got %0d", want.kind, kind);
        errors++;
      end
      if (last_flag !== want.last_flag) begin
        $error("last_of_table: expected %0b, got %0b", want.last_flag, last_flag);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        in_valid_i      = 1'b0;
  logic [7:0]  code_byte_i     = 8'h00;
  logic        table_end_i     = 1'b0;
  logic        out_stall_i     = 1'b0;
  logic        in_stall_o;
  logic        out_valid_o;
  logic [31:0] reloc_offset_o;
  logic [1:0]  reloc_kind_o;
  logic        last_of_table_o;

  reloc_tracker track = new();

  int unsigned bytes_sent = 0;
  int unsigned cycle_cnt  = 0;
  bit          gaps_on    = 1'b1;  // sender may idle
  bit          calm       = 1'b0;  // receiver never stalls
  bit          hold_req   = 1'b0;  // ask for the long hold-off

  relocation_stream_decoder u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .code_byte_i    (code_byte_i),
    .table_end_i    (table_end_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .reloc_offset_o (reloc_offset_o),
    .reloc_kind_o   (reloc_kind_o),
    .last_of_table_o(last_of_table_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog: a hung handshake ends the run here.
  initial begin
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("TEST FAILED");
    $finish;
  end

  // Both handshakes are sampled at the edge, before any driver update lands.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) track.take_byte(code_byte_i, table_end_i);
      if (out_valid_o && !out_stall_i)
        track.match_reloc(reloc_offset_o, reloc_kind_o, last_of_table_o);
    end
  end

  // Result side: short stall bursts, quiet stretches, one long hold-off.
  initial begin
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
        out_stall_i <= 1'b0;
        hold_req = 1'b0;
        @(posedge clk_i);
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
        out_stall_i <= 1'b0;
        @(posedge clk_i);
      end else if ($urandom_range(0, 63) == 0) begin
        repeat ($urandom_range(20, 60)) @(posedge clk_i);
      end else begin
        @(posedge clk_i);
      end
    end
  end

  // Offer one code beat and wait for it to be taken; maybe idle afterwards.
  // Valid stays high between back-to-back beats.
  task automatic send_code(input logic [7:0] b, input logic tbl_end);
    code_byte_i <= b;
    table_end_i <= tbl_end;
    in_valid_i  <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    bytes_sent++;
    if (gaps_on && !hold_req && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  endtask

  initial begin
    int unsigned len;
    logic [7:0]  b;
    bit          hold_done;
    hold_done = 1'b0;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // --- directed tables ---
    send_code(8'h00, 1'b1);          // zero step then end: offset entry at 0
    send_code(8'h00, 1'b0);
    send_code(8'h00, 1'b1);          // selector ends the table
    send_code(8'h08, 1'b1);          // scale only: end marker alone
    send_code(8'h80, 1'b1);          // plain digit 0x08 at end
    // largest advance, scaled until it wraps, then a plain max digit
    send_code(8'hFF, 1'b0);
    send_code(8'h08, 1'b0);
    send_code(8'h08, 1'b0);
    send_code(8'h08, 1'b0);
    send_code(8'hF7, 1'b0);
    send_code(8'hFF, 1'b0);          // pending entry leaves on an advance byte
    send_code(8'h08, 1'b0);
    send_code(8'h08, 1'b0);
    send_code(8'h08, 1'b0);
    send_code(8'h00, 1'b0);          // zero step opens an entry at wrapped offset
    send_code(8'h00, 1'b0);          // ... which becomes a selector
    send_code(8'h77, 1'b0);
    send_code(8'h0F, 1'b0);          // advance byte flushes the plain entry
    send_code(8'h10, 1'b0);
    send_code(8'hF0, 1'b1);          // two results from the last byte

    // --- random tables and stray bytes ---
    while (bytes_sent < CodeItems) begin
      if (bytes_sent >= CodeItems - TailItems) begin
        gaps_on = 1'b0;
        calm    = 1'b1;
      end else begin
        gaps_on = ($urandom_range(0, 3) != 0);
      end
      if (!hold_done && bytes_sent >= HoldAtItem) begin
        hold_req  = 1'b1;
        hold_done = 1'b1;
      end
      if ($urandom_range(0, 6) == 0) begin
        // noise: any byte, sometimes cutting a table short
        b = 8'($urandom);
        send_code(b, $urandom_range(0, 3) == 0);
      end else begin
        len = $urandom_range(1, 12);
        for (int unsigned i = 0; i < len; i++) begin
          case ($urandom_range(0, 9))
            0, 1, 2, 3: begin     // plain digit
              b    = 8'($urandom);
              b[3] = 1'b0;
              if (b == rsd_pkg::ByteSelector) b = 8'h10;
            end
            4, 5: begin           // banked advance
              b    = 8'($urandom);
              b[3] = 1'b1;
              if (b == rsd_pkg::ByteScale) b = 8'h88;
            end
            6:       b = rsd_pkg::ByteScale;
            7, 8:    b = rsd_pkg::ByteSelector;
            default: b = 8'($urandom);
          endcase
          send_code(b, i == len - 1);
        end
      end
    end

    in_valid_i <= 1'b0;
    while (track.due_relocs.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (track.errors == 0 && track.due_relocs.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
src/rsd_pkg.sv
src/rsd_front.sv
src/rsd_queue.sv
src/rsd_back.sv
src/relocation_stream_decoder.sv
sim/tb.sv
